@@ sv/rirw_pkg.sv @@
package rirw_pkg;

  // Result codes
  typedef enum logic [2:0] {
    VERD_AHEAD  = 3'd0,
    VERD_NEW_IN = 3'd1,
    VERD_DUP    = 3'd2,
    VERD_OLD    = 3'd3,
    VERD_UNREL  = 3'd4
  } rirw_verdict_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SHIFT
  } rirw_state_t;

  // Control shared by every cell of the bitmap row
  typedef struct packed {
    logic shift;  // take the neighbor's bit
    logic clear;  // drop the bit
  } rirw_cell_ctl_t;

endpackage

@@ sv/rirw_if.sv @@
interface rirw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] msg_id;
  logic        is_reliable;

  modport source (output valid, output msg_id, output is_reliable, input ready);
  modport sink   (input valid, input msg_id, input is_reliable, output ready);
endinterface

interface rirw_out_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic [2:0] verdict;

  modport source (output valid, output accept, output verdict, input ready);
  modport sink   (input valid, input accept, input verdict, output ready);
endinterface

@@ sv/rirw_cell.sv @@
module rirw_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rirw_pkg::rirw_cell_ctl_t ctl,
  input  logic                    mark,
  input  logic                    prev_bit,
  output logic                    seen
);
  import rirw_pkg::*;

  logic seen_r;
  logic seen_nxt;

  // clear or shift first, then set the mark on top
  always_comb begin
    if (ctl.clear) begin
      seen_nxt = 1'b0;
    end else if (ctl.shift) begin
      seen_nxt = prev_bit;
    end else begin
      seen_nxt = seen_r;
    end
    seen_nxt = seen_nxt | mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  assign seen = seen_r;

endmodule

@@ sv/rirw_ctrl.sv @@
module rirw_ctrl #(
  parameter int WINDOW = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_msg_id,
  input  logic                     in_is_reliable,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_accept,
  output logic [2:0]               out_verdict,
  input  logic [WINDOW-1:0]        bitmap,
  output rirw_pkg::rirw_cell_ctl_t cell_ctl,
  output logic [WINDOW-1:0]        mark
);
  import rirw_pkg::*;

  localparam int          IW      = $clog2(WINDOW);
  localparam logic [15:0] WIN16   = 16'(WINDOW);
  localparam logic [15:0] OLD_LIM = 16'(32767 + WINDOW - 1);

  rirw_state_t   state_r, state_nxt;
  logic [15:0]   id_r, id_nxt;
  logic          rel_r, rel_nxt;
  logic [15:0]   highest_r, highest_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_accept_r, out_accept_nxt;
  rirw_verdict_t out_verdict_r, out_verdict_nxt;

  logic [15:0]   dist_back;
  logic [15:0]   dist_ahead;
  logic [IW-1:0] e_idx;
  logic          in_win;
  logic          too_old;
  logic          hit;
  logic          slot_free;

  // serial-number classification of the held word
  always_comb begin
    dist_back  = highest_r - id_r;
    dist_ahead = id_r - highest_r;
    e_idx      = dist_back[IW-1:0];
    in_win     = dist_back < WIN16;
    too_old    = !in_win && (dist_back <= OLD_LIM);
    hit        = bitmap[e_idx];
    slot_free  = !out_valid_r || out_ready;
  end

  // next state, cell control and result
  always_comb begin
    state_nxt       = state_r;
    id_nxt          = id_r;
    rel_nxt         = rel_r;
    highest_nxt     = highest_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_accept_nxt  = out_accept_r;
    out_verdict_nxt = out_verdict_r;
    cell_ctl        = '0;
    mark            = '0;
    in_ready        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          id_nxt    = in_msg_id;
          rel_nxt   = in_is_reliable;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!rel_r) begin
            out_accept_nxt  = 1'b1;
            out_verdict_nxt = VERD_UNREL;
          end else if (in_win) begin
            if (hit) begin
              out_accept_nxt  = 1'b0;
              out_verdict_nxt = VERD_DUP;
            end else begin
              mark[e_idx]     = 1'b1;
              out_accept_nxt  = 1'b1;
              out_verdict_nxt = VERD_NEW_IN;
            end
          end else if (too_old) begin
            out_accept_nxt  = 1'b0;
            out_verdict_nxt = VERD_OLD;
          end else begin
            highest_nxt = id_r;
            if (dist_ahead >= WIN16) begin
              // window jumps past every slot
              cell_ctl.clear  = 1'b1;
              mark[0]         = 1'b1;
              out_accept_nxt  = 1'b1;
              out_verdict_nxt = VERD_AHEAD;
            end else begin
              // short advance: walk the row one slot a cycle
              out_valid_nxt = out_valid_r && !out_ready;
              cnt_nxt       = dist_ahead[IW-1:0];
              state_nxt     = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        cell_ctl.shift = 1'b1;
        cnt_nxt        = cnt_r - IW'(1);
        if (cnt_r == IW'(1)) begin
          mark[0]         = 1'b1;
          out_valid_nxt   = 1'b1;
          out_accept_nxt  = 1'b1;
          out_verdict_nxt = VERD_AHEAD;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      highest_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      highest_r   <= highest_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    rel_r         <= rel_nxt;
    out_accept_r  <= out_accept_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_accept  = out_accept_r;
  assign out_verdict = out_verdict_r;

endmodule

@@ sv/reliable_id_replay_window_core.sv @@
// Channel   Dir  Payload                       Handshake
// in_word   in   msg_id[15:0], is_reliable     valid/ready
// out_word  out  accept, verdict[2:0]          valid/ready
//
// One word at a time: unreliable, in-window, duplicate, too-old and far-ahead
// ids are evaluated directly; an id ahead by d < WINDOW also walks the
// bitmap row d slots, one slot per cycle, before its result.
// Synchronous active-low reset clears highest id, bitmap and output valid.
// A new word is taken while a result waits; evaluation holds until the
// output register is free.
module reliable_id_replay_window_core #(
  parameter int WINDOW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  rirw_in_if.sink           in_word,
  rirw_out_if.source        out_word
);
  import rirw_pkg::*;

  rirw_cell_ctl_t    cell_ctl;
  logic [WINDOW-1:0] mark;
  logic [WINDOW-1:0] bitmap;

  rirw_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_word.valid),
    .in_ready       (in_word.ready),
    .in_msg_id      (in_word.msg_id),
    .in_is_reliable (in_word.is_reliable),
    .out_valid      (out_word.valid),
    .out_ready      (out_word.ready),
    .out_accept     (out_word.accept),
    .out_verdict    (out_word.verdict),
    .bitmap         (bitmap),
    .cell_ctl       (cell_ctl),
    .mark           (mark)
  );

  // bitmap row: slot k marks id highest - k, shifts toward higher k
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    logic prev_bit;
    if (k == 0) begin : g_head
      assign prev_bit = 1'b0;
    end else begin : g_body
      assign prev_bit = bitmap[k-1];
    end

    rirw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .mark     (mark[k]),
      .prev_bit (prev_bit),
      .seen     (bitmap[k])
    );
  end

endmodule

@@ tb/replay_window_scoreboard.sv @@
`timescale 1ns / 100ps

// Watches both channels of the replay window, predicts one result word per
// accepted input word and compares each accepted result with the oldest
// prediction.
module replay_window_scoreboard #(
  parameter int WINDOW = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_msg_id,
  input  logic        in_is_reliable,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_accept,
  input  logic [2:0]  out_verdict,
  output int          fail_count,
  output int          pending_count
);
  import rirw_pkg::*;

  typedef struct packed {
    logic          accept;
    rirw_verdict_t verdict;
  } window_result_t;

  // Largest distance behind the top id that still counts as too old
  localparam int OLD_EDGE = 32'h7FFF + WINDOW - 1;

  // Predicted window: top id and one seen bit per slot, bit k = top - k
  logic [15:0]        win_top;
  logic [WINDOW-1:0]  seen_map;
  window_result_t     expected_words[$];
  int                 fail_tally = 0;
  int                 pending_words = 0;

  assign fail_count    = fail_tally;
  assign pending_count = pending_words;

  // Classify one id against the window and update the predicted state
  function automatic window_result_t classify_id(input logic [15:0] id,
                                                 input logic rel);
    logic [15:0]    behind;
    int unsigned    ahead;
    window_result_t res;
    if (!rel) begin
      res.accept  = 1'b1;
      res.verdict = VERD_UNREL;
      return res;
    end
    behind = win_top - id;
    if (behind < WINDOW) begin
      if (seen_map[behind]) begin
        res.accept  = 1'b0;
        res.verdict = VERD_DUP;
      end else begin
        seen_map[behind] = 1'b1;
        res.accept  = 1'b1;
        res.verdict = VERD_NEW_IN;
      end
    end else if (behind <= OLD_EDGE) begin
      res.accept  = 1'b0;
      res.verdict = VERD_OLD;
    end else begin
      // ahead: slide the window, slots entering it start clear
      ahead = 32'h10000 - behind;
      if (ahead >= WINDOW) seen_map = '0;
      else seen_map = seen_map << ahead;
      seen_map[0] = 1'b1;
      win_top     = id;
      res.accept  = 1'b1;
      res.verdict = VERD_AHEAD;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    window_result_t want;
    if (!rst_n) begin
      win_top  = '0;
      seen_map = '0;
      expected_words.delete();
    end else begin
      // result side first: a word leaving now belongs to an earlier input
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: accept=%0d verdict=%0d",
                 out_accept, out_verdict);
          fail_tally++;
        end else begin
          want = expected_words.pop_front();
          if (out_accept !== want.accept) begin
            $error("accept mismatch: expected %0d, got %0d", want.accept, out_accept);
            fail_tally++;
          end
          if (out_verdict !== want.verdict) begin
            $error("verdict mismatch: expected %0d, got %0d", want.verdict, out_verdict);
            fail_tally++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_words = {expected_words, classify_id(in_msg_id, in_is_reliable)};
    end
    pending_words = expected_words.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import rirw_pkg::*;

  localparam int WIN          = 32;
  localparam int OLD_EDGE     = 32'h7FFF + WIN - 1;
  localparam int PHASE_WORDS  = 467;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  logic [15:0] id_cursor = '0;

  rirw_in_if  in_word();
  rirw_out_if out_word();

  reliable_id_replay_window_core #(
    .WINDOW(WIN)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .out_word(out_word)
  );

  replay_window_scoreboard #(
    .WINDOW(WIN)
  ) scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_word.valid),
    .in_ready      (in_word.ready),
    .in_msg_id     (in_word.msg_id),
    .in_is_reliable(in_word.is_reliable),
    .out_valid     (out_word.valid),
    .out_ready     (out_word.ready),
    .out_accept    (out_word.accept),
    .out_verdict   (out_word.verdict),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  initial begin
    in_word.valid       = 1'b0;
    in_word.msg_id      = '0;
    in_word.is_reliable = 1'b0;
    out_word.ready      = 1'b0;
  end

  // Result side stalls at random
  always @(negedge clk) begin
    out_word.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with a random gap first; returns at the next falling edge
  task automatic send_word(input logic [15:0] id, input logic rel);
    int gap;
    logic [15:0] behind;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word.valid       <= 1'b1;
    in_word.msg_id      <= id;
    in_word.is_reliable <= rel;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    // follow the top id so random ids can be placed around the window
    behind = id_cursor - id;
    if (rel && behind > OLD_EDGE) id_cursor = id;
    @(negedge clk);
  endtask

  // Hold off the input until every result has come back
  task automatic wait_drained();
    in_word.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic send_random_word();
    int pick;
    logic [15:0] id;
    logic rel;
    pick = $urandom_range(0, 99);
    rel  = 1'b1;
    if (pick < 34) begin
      // short step ahead, mostly small
      if ($urandom_range(0, 3) == 0) id = 16'(id_cursor + $urandom_range(1, WIN - 1));
      else id = 16'(id_cursor + $urandom_range(1, 4));
    end else if (pick < 58)
      id = 16'(id_cursor - $urandom_range(0, WIN - 1));
    else if (pick < 68)
      id = 16'(id_cursor - $urandom_range(0, 3));
    else if (pick < 76) begin
      if ($urandom_range(0, 3) == 0)
        id = 16'(id_cursor - ($urandom_range(0, 1) ? WIN : OLD_EDGE));
      else id = 16'(id_cursor - $urandom_range(WIN, OLD_EDGE));
    end else if (pick < 81) begin
      // far ahead, including the largest step that still counts as ahead
      if ($urandom_range(0, 3) == 0)
        id = 16'(id_cursor + ($urandom_range(0, 1) ? WIN : 32'h10000 - OLD_EDGE - 1));
      else id = 16'(id_cursor + $urandom_range(WIN, 32'h10000 - OLD_EDGE - 1));
    end else if (pick < 89) begin
      id  = 16'($urandom_range(0, 16'hFFFF));
      rel = 1'b0;
    end else
      id = 16'($urandom_range(0, 16'hFFFF));
    send_word(id, rel);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: after reset the slots at and below id 0 are open once each
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'hFFE1, 1'b1);
    send_word(16'hFFE1, 1'b1);
    send_word(16'hFFE0, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h7FE2, 1'b1);
    send_word(16'h0001, 1'b1);
    send_word(16'h0020, 1'b1);
    send_word(16'h0040, 1'b1);
    send_word(16'h003F, 1'b1);
    send_word(16'h0021, 1'b1);
    send_word(16'h0040, 1'b1);
    send_word(16'h0020, 1'b1);
    send_word(16'h8021, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h001E, 1'b1);
    send_word(16'hFFFF, 1'b1);
    send_word(16'h5555, 1'b0);

    // Random: three idling profiles, draining fully before each
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) send_random_word();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rirw_pkg.sv
sv/rirw_if.sv
sv/rirw_cell.sv
sv/rirw_ctrl.sv
sv/reliable_id_replay_window_core.sv
tb/replay_window_scoreboard.sv
tb/testbench.sv
